[hdl/sge_pkg.sv]
`timescale 1ns / 1ps

package sge_pkg;

    // build-time sizing
    localparam int MAX_SIDE    = 64;
    localparam int SAMPLE_BITS = 16;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int ENERGY_W   = 64;
    localparam int DIMS_W     = 2;
    localparam int SIDE_LEN_W = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    // derived widths
    localparam int CNT_W       = $clog2(MAX_SIDE);
    localparam int SPAN_W      = CNT_W + 1;
    localparam int CMP_W       = (SIDE_LEN_W > SPAN_W) ? SIDE_LEN_W : SPAN_W;
    localparam int PLANE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int PLANE_AW    = 2 * CNT_W;
    localparam int EXT_W       = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int NSUM_W      = SAMPLE_BITS + 2;
    localparam int FACT_W      = SAMPLE_BITS + 5;
    localparam int PROD_W      = SAMPLE_BITS + FACT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = CFG_IDX_W'(1);

    // dimension codes, zero behaves as one dimension
    localparam logic [DIMS_W-1:0] DIMS_NONE  = DIMS_W'(0);
    localparam logic [DIMS_W-1:0] DIMS_ONE   = DIMS_W'(1);
    localparam logic [DIMS_W-1:0] DIMS_TWO   = DIMS_W'(2);
    localparam logic [DIMS_W-1:0] DIMS_THREE = DIMS_W'(3);

    localparam logic [SIDE_LEN_W-1:0] SIDE_RESET = SIDE_LEN_W'(MAX_SIDE);

    // diagonal weight as a left shift of the sample
    localparam logic [1:0] DIAG_SHIFT_1D = 2'd1;
    localparam logic [1:0] DIAG_SHIFT_2D = 2'd2;
    localparam logic [1:0] DIAG_SHIFT_3D = 2'd3;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    typedef logic signed [SAMPLE_BITS-1:0] samp_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic       use_up;
        logic       use_plane;
        logic [1:0] shift;
    } sge_ctl_t;

    function automatic samp_t extend_sample(input logic [SAMPLE_W-1:0] raw);
        logic signed [EXT_W-1:0] wide;
        wide = EXT_W'(signed'(raw));
        return wide[SAMPLE_BITS-1:0];
    endfunction

endpackage

[hdl/sge_if.sv]
`timescale 1ns / 1ps

interface sge_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sge_pkg::SAMPLE_W-1:0]  sample;
    logic                                 last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface sge_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sge_pkg::ENERGY_W-1:0]  energy;
    logic                                 saturated;

    modport source (output valid, output energy, output saturated, input ready);
    modport sink   (input valid, input energy, input saturated, output ready);
endinterface

[hdl/stencil_grid_energy_top.sv]
`timescale 1ns / 1ps

// Streams a grid vector in raster order (innermost index fastest) and returns x'Lx for the
// 1D/2D/3D grid Laplacian, one sample per clock while no finished result waits in the output
// register. The pipeline is neighbor fetch, term factor, one 16x21 multiply and a saturating
// 64-bit accumulate. Upper and previous-plane neighbors live in two single-port-read RAMs
// (MAX_SIDE and MAX_SIDE*MAX_SIDE words), each read and overwritten at the sample's own
// grid position in the cycle it is taken, so no forwarding is needed and no clearing pass
// runs after reset. The input stalls only while a finished result waits in the output
// register. Writing either register restarts the vector.
module stencil_grid_energy_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sge_pkg::CFG_DATA_W-1:0] cfg_data,
    sge_sample_if.sink                     samples,
    sge_result_if.source                   results
);

    logic                                 adv;
    logic                                 restart;
    logic                                 row_we;
    logic [sge_pkg::CNT_W-1:0]            row_addr;
    logic                                 plane_we;
    logic [sge_pkg::PLANE_AW-1:0]         plane_addr;
    sge_pkg::samp_t                       wr_sample;
    sge_pkg::sge_ctl_t                    s1_ctl;
    sge_pkg::samp_t                       s1_x;
    sge_pkg::samp_t                       s1_left;
    logic [sge_pkg::SAMPLE_BITS-1:0]      row_data;
    logic [sge_pkg::SAMPLE_BITS-1:0]      plane_data;
    sge_pkg::sge_ctl_t                    s3_ctl;
    logic signed [sge_pkg::PROD_W-1:0]    s3_prod;

    sge_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .samples    (samples),
        .adv        (adv),
        .restart    (restart),
        .row_we     (row_we),
        .row_addr   (row_addr),
        .plane_we   (plane_we),
        .plane_addr (plane_addr),
        .wr_sample  (wr_sample),
        .s1_ctl     (s1_ctl),
        .s1_x       (s1_x),
        .s1_left    (s1_left)
    );

    sge_ram #(
        .WIDTH (sge_pkg::SAMPLE_BITS),
        .DEPTH (sge_pkg::MAX_SIDE)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (row_we),
        .wr_addr (row_addr),
        .wr_data (wr_sample),
        .rd_en   (adv),
        .rd_addr (row_addr),
        .rd_data (row_data)
    );

    sge_ram #(
        .WIDTH (sge_pkg::SAMPLE_BITS),
        .DEPTH (sge_pkg::PLANE_DEPTH)
    ) u_plane_ram (
        .clk     (clk),
        .wr_en   (plane_we),
        .wr_addr (plane_addr),
        .wr_data (wr_sample),
        .rd_en   (adv),
        .rd_addr (plane_addr),
        .rd_data (plane_data)
    );

    sge_term u_term (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .s1_ctl     (s1_ctl),
        .s1_x       (s1_x),
        .s1_left    (s1_left),
        .row_data   (row_data),
        .plane_data (plane_data),
        .s3_ctl     (s3_ctl),
        .s3_prod    (s3_prod)
    );

    sge_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .s3_ctl  (s3_ctl),
        .s3_prod (s3_prod),
        .adv     (adv),
        .results (results)
    );

endmodule

[hdl/sge_ram.sv]
`timescale 1ns / 1ps

module sge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sge_front.sv]
`timescale 1ns / 1ps

module sge_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sge_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sge_pkg::CFG_DATA_W-1:0]       cfg_data,
    sge_sample_if.sink                           samples,
    input  logic                                 adv,
    output logic                                 restart,
    output logic                                 row_we,
    output logic [sge_pkg::CNT_W-1:0]            row_addr,
    output logic                                 plane_we,
    output logic [sge_pkg::PLANE_AW-1:0]         plane_addr,
    output sge_pkg::samp_t                       wr_sample,
    output sge_pkg::sge_ctl_t                    s1_ctl,
    output sge_pkg::samp_t                       s1_x,
    output sge_pkg::samp_t                       s1_left
);

    logic [sge_pkg::DIMS_W-1:0]     dims_reg, dims_next;
    logic [sge_pkg::SIDE_LEN_W-1:0] side_reg, side_next;
    logic [sge_pkg::CNT_W-1:0]      col_reg, col_next;
    logic [sge_pkg::CNT_W-1:0]      row_reg, row_next;
    logic [sge_pkg::CNT_W-1:0]      slice_reg, slice_next;
    sge_pkg::samp_t                 prev_reg, prev_next;
    sge_pkg::sge_ctl_t              s1_ctl_reg, s1_ctl_next;
    sge_pkg::samp_t                 s1_x_reg;
    sge_pkg::samp_t                 s1_left_reg;

    logic                        accept;
    logic                        is_1d;
    logic                        is_3d;
    logic [sge_pkg::CMP_W-1:0]   side_len;
    logic [sge_pkg::CMP_W-1:0]   side_eff;
    logic                        col_end;
    logic                        row_end;
    logic                        slice_end;
    sge_pkg::samp_t              x;

    assign samples.ready = adv;
    assign accept        = samples.valid && adv;
    assign x             = sge_pkg::extend_sample(samples.sample);

    assign is_1d = (dims_reg == sge_pkg::DIMS_NONE) || (dims_reg == sge_pkg::DIMS_ONE);
    assign is_3d = (dims_reg == sge_pkg::DIMS_THREE);

    always_comb
    begin
        side_len = sge_pkg::CMP_W'(side_reg);
        if (side_len == '0)
        begin
            side_eff = sge_pkg::CMP_W'(1);
        end
        else if (side_len > sge_pkg::CMP_W'(sge_pkg::MAX_SIDE))
        begin
            side_eff = sge_pkg::CMP_W'(sge_pkg::MAX_SIDE);
        end
        else
        begin
            side_eff = side_len;
        end
    end

    assign col_end   = (sge_pkg::CMP_W'(col_reg) + sge_pkg::CMP_W'(1)) >= side_eff;
    assign row_end   = (sge_pkg::CMP_W'(row_reg) + sge_pkg::CMP_W'(1)) >= side_eff;
    assign slice_end = (sge_pkg::CMP_W'(slice_reg) + sge_pkg::CMP_W'(1)) >= side_eff;

    // config decode: a write to a known register restarts the vector
    always_comb
    begin
        dims_next = dims_reg;
        side_next = side_reg;
        restart   = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sge_pkg::CFG_DIMENSIONS:
                begin
                    dims_next = cfg_data[sge_pkg::DIMS_W-1:0];
                    restart   = 1'b1;
                end
                sge_pkg::CFG_SIDE_LENGTH:
                begin
                    side_next = cfg_data[sge_pkg::SIDE_LEN_W-1:0];
                    restart   = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // raster position
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        slice_next = slice_reg;
        prev_next  = prev_reg;
        if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            slice_next = '0;
            prev_next  = '0;
        end
        else if (accept)
        begin
            if (samples.last)
            begin
                col_next   = '0;
                row_next   = '0;
                slice_next = '0;
                prev_next  = '0;
            end
            else
            begin
                prev_next = x;
                if (is_1d)
                begin
                    // only marks that a sample has been seen
                    col_next = sge_pkg::CNT_W'(1);
                end
                else if (!col_end)
                begin
                    col_next = col_reg + sge_pkg::CNT_W'(1);
                end
                else
                begin
                    col_next = '0;
                    if (!row_end)
                    begin
                        row_next = row_reg + sge_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        row_next = '0;
                        if (is_3d)
                        begin
                            slice_next = slice_end ? '0 : slice_reg + sge_pkg::CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_ctl_next.valid     = samples.valid;
        s1_ctl_next.last      = samples.last;
        s1_ctl_next.use_up    = !is_1d && (row_reg != '0);
        s1_ctl_next.use_plane = is_3d && (slice_reg != '0);
        if (is_1d)
        begin
            s1_ctl_next.shift = sge_pkg::DIAG_SHIFT_1D;
        end
        else if (is_3d)
        begin
            s1_ctl_next.shift = sge_pkg::DIAG_SHIFT_3D;
        end
        else
        begin
            s1_ctl_next.shift = sge_pkg::DIAG_SHIFT_2D;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg   <= sge_pkg::DIMS_TWO;
            side_reg   <= sge_pkg::SIDE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            slice_reg  <= '0;
            prev_reg   <= '0;
            s1_ctl_reg <= '0;
        end
        else
        begin
            dims_reg  <= dims_next;
            side_reg  <= side_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            slice_reg <= slice_next;
            prev_reg  <= prev_next;
            if (adv)
            begin
                s1_ctl_reg <= s1_ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg    <= x;
            s1_left_reg <= (col_reg != '0) ? prev_reg : '0;
        end
    end

    // neighbors are fetched at the sample's own position, then overwritten by it
    assign row_addr   = col_reg;
    assign plane_addr = {row_reg, col_reg};
    assign row_we     = accept && !is_1d;
    assign plane_we   = accept && is_3d;
    assign wr_sample  = x;

    assign s1_ctl  = s1_ctl_reg;
    assign s1_x    = s1_x_reg;
    assign s1_left = s1_left_reg;

`ifndef SYNTHESIS
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        !is_1d |-> (sge_pkg::CMP_W'(col_reg) < side_eff))
        else $error("column position outside the grid");

    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (col_reg == '0 && row_reg == '0 && slice_reg == '0 && prev_reg == '0))
        else $error("vector restart did not return to the origin");
`endif

endmodule

[hdl/sge_term.sv]
`timescale 1ns / 1ps

module sge_term (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  sge_pkg::sge_ctl_t                    s1_ctl,
    input  sge_pkg::samp_t                       s1_x,
    input  sge_pkg::samp_t                       s1_left,
    input  logic [sge_pkg::SAMPLE_BITS-1:0]      row_data,
    input  logic [sge_pkg::SAMPLE_BITS-1:0]      plane_data,
    output sge_pkg::sge_ctl_t                    s3_ctl,
    output logic signed [sge_pkg::PROD_W-1:0]    s3_prod
);

    logic signed [sge_pkg::NSUM_W-1:0] nsum;
    logic signed [sge_pkg::NSUM_W-1:0] up_term;
    logic signed [sge_pkg::NSUM_W-1:0] plane_term;
    logic signed [sge_pkg::FACT_W-1:0] factor;
    logic signed [sge_pkg::PROD_W-1:0] prod;

    sge_pkg::sge_ctl_t                 s2_ctl_reg;
    sge_pkg::samp_t                    s2_x_reg;
    logic signed [sge_pkg::FACT_W-1:0] s2_factor_reg;
    sge_pkg::sge_ctl_t                 s3_ctl_reg;
    logic signed [sge_pkg::PROD_W-1:0] s3_prod_reg;

    assign up_term    = s1_ctl.use_up ? sge_pkg::NSUM_W'(signed'(row_data)) : '0;
    assign plane_term = s1_ctl.use_plane ? sge_pkg::NSUM_W'(signed'(plane_data)) : '0;
    assign nsum       = sge_pkg::NSUM_W'(s1_left) + up_term + plane_term;

    // diag*x - 2*(sum of earlier neighbors)
    assign factor = (sge_pkg::FACT_W'(s1_x) <<< s1_ctl.shift)
                  - (sge_pkg::FACT_W'(nsum) <<< 1);

    assign prod = sge_pkg::PROD_W'(s2_x_reg) * sge_pkg::PROD_W'(s2_factor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s2_ctl_reg <= s1_ctl;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_x_reg      <= s1_x;
            s2_factor_reg <= factor;
            s3_prod_reg   <= prod;
        end
    end

    assign s3_ctl  = s3_ctl_reg;
    assign s3_prod = s3_prod_reg;

endmodule

[hdl/sge_accum.sv]
`timescale 1ns / 1ps

module sge_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 restart,
    input  sge_pkg::sge_ctl_t                    s3_ctl,
    input  logic signed [sge_pkg::PROD_W-1:0]    s3_prod,
    output logic                                 adv,
    sge_result_if.source                         results
);

    logic [sge_pkg::ENERGY_W-1:0] acc_reg, acc_next;
    logic                         clip_reg, clip_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sge_pkg::ENERGY_W-1:0] energy_reg, energy_next;
    logic                         sat_reg, sat_next;

    logic [sge_pkg::ENERGY_W-1:0] term;
    logic [sge_pkg::ENERGY_W-1:0] sum;
    logic                         ovf;
    logic [sge_pkg::ENERGY_W-1:0] acc_new;
    logic                         clip_new;
    logic                         take;

    // whole pipeline moves unless a result is stuck in the output register
    assign adv  = !out_valid_reg || results.ready;
    assign take = adv && s3_ctl.valid;

    assign term = sge_pkg::ENERGY_W'(s3_prod);
    assign sum  = acc_reg + term;
    assign ovf  = (acc_reg[sge_pkg::ENERGY_W-1] == term[sge_pkg::ENERGY_W-1])
               && (sum[sge_pkg::ENERGY_W-1] != acc_reg[sge_pkg::ENERGY_W-1]);

    always_comb
    begin
        if (ovf)
        begin
            acc_new = acc_reg[sge_pkg::ENERGY_W-1] ? sge_pkg::ENERGY_MIN : sge_pkg::ENERGY_MAX;
        end
        else
        begin
            acc_new = sum;
        end
        clip_new = clip_reg || ovf;
    end

    always_comb
    begin
        acc_next       = acc_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !results.ready;
        energy_next    = energy_reg;
        sat_next       = sat_reg;
        if (restart)
        begin
            acc_next  = '0;
            clip_next = 1'b0;
        end
        else if (take)
        begin
            if (s3_ctl.last)
            begin
                energy_next    = acc_new;
                sat_next       = clip_new;
                out_valid_next = 1'b1;
                acc_next       = '0;
                clip_next      = 1'b0;
            end
            else
            begin
                acc_next  = acc_new;
                clip_next = clip_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        sat_reg    <= sat_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.energy    = energy_reg;
    assign results.saturated = sat_reg;

`ifndef SYNTHESIS
    a_clip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (clip_reg && !restart && !(take && s3_ctl.last)) |=> clip_reg)
        else $error("clip flag dropped inside a vector");

    a_clear_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s3_ctl.last) |=> (acc_reg == '0 && !clip_reg && out_valid_reg))
        else $error("accumulator not cleared after the closing sample");
`endif

endmodule

[dv/tb_stencil_grid_energy_top.sv]
`timescale 1ns / 1ps

module tb_stencil_grid_energy_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_DRAIN   = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PLANE_SIDE   = 16;

    localparam logic [sge_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_FIRST =
        sge_pkg::CFG_SIDE_LENGTH + 1'b1;
    localparam logic [sge_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LAST = '1;

    localparam logic signed [sge_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
        {1'b0, {(sge_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [sge_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
        {1'b1, {(sge_pkg::SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [sge_pkg::ENERGY_W-1:0] energy;
        logic                                saturated;
    } energy_result_t;

    typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_PATTERN, DRAIN_SLOW} drain_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [sge_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sge_pkg::CFG_DATA_W-1:0] cfg_data;

    sge_sample_if sample_bus ();
    sge_result_if result_bus ();

    stencil_grid_energy_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_bus),
        .results   (result_bus)
    );

    // predicted block state
    logic [sge_pkg::DIMS_W-1:0]           grid_dims;
    logic [sge_pkg::SIDE_LEN_W-1:0]       grid_side;
    logic signed [sge_pkg::SAMPLE_W-1:0]  prev_x;
    logic signed [sge_pkg::SAMPLE_W-1:0]  row_mem [sge_pkg::MAX_SIDE];
    logic signed [sge_pkg::SAMPLE_W-1:0]  plane_mem [sge_pkg::PLANE_DEPTH];
    int unsigned                          col_pos;
    int unsigned                          row_pos;
    int unsigned                          slice_pos;
    logic signed [sge_pkg::ENERGY_W-1:0]  energy_acc;
    logic                                 clipped;

    energy_result_t pending_energy[$];

    int          mismatch_count;
    int          items_sent;
    int          cycle_count;
    int          hold_requests;
    int          burst_left;
    bit          sender_bursty;
    drain_mode_t drain_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d, %0d results outstanding", cycle_count,
                     pending_energy.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void clear_vector();
        prev_x     = '0;
        col_pos    = 0;
        row_pos    = 0;
        slice_pos  = 0;
        energy_acc = '0;
        clipped    = 1'b0;
    endfunction

    function automatic int unsigned active_side();
        if (grid_side == 0)
            return 1;
        if (grid_side > sge_pkg::MAX_SIDE)
            return sge_pkg::MAX_SIDE;
        return grid_side;
    endfunction

    // fold one sample into the predicted energy, queue the sum on the last beat
    function automatic void absorb_sample(input logic signed [sge_pkg::SAMPLE_W-1:0] x,
                                          input bit is_last);
        int unsigned                         side;
        int unsigned                         inner;
        int unsigned                         mid;
        longint                              diag;
        longint                              nbr_sum;
        longint                              term;
        logic signed [sge_pkg::ENERGY_W-1:0] total;
        energy_result_t                      due;
        side    = active_side();
        inner   = col_pos;
        mid     = row_pos;
        nbr_sum = 0;
        if (grid_dims <= sge_pkg::DIMS_ONE)
        begin
            diag = 2;
            if (col_pos != 0)
                nbr_sum += prev_x;
            col_pos = 1;
        end
        else
        begin
            diag = (grid_dims == sge_pkg::DIMS_TWO) ? 4 : 8;
            if (inner != 0)
                nbr_sum += prev_x;
            if (mid != 0)
                nbr_sum += row_mem[inner];
            if (grid_dims == sge_pkg::DIMS_THREE && slice_pos != 0)
                nbr_sum += plane_mem[mid * sge_pkg::MAX_SIDE + inner];
            row_mem[inner] = x;
            if (grid_dims == sge_pkg::DIMS_THREE)
                plane_mem[mid * sge_pkg::MAX_SIDE + inner] = x;
            if (inner + 1 >= side)
            begin
                col_pos = 0;
                if (mid + 1 >= side)
                begin
                    row_pos = 0;
                    if (grid_dims == sge_pkg::DIMS_THREE)
                        slice_pos = (slice_pos + 1 >= side) ? 0 : slice_pos + 1;
                end
                else
                begin
                    row_pos = mid + 1;
                end
            end
            else
            begin
                col_pos = inner + 1;
            end
        end
        prev_x = x;
        term   = longint'(x) * (diag * longint'(x) - 2 * nbr_sum);
        total  = energy_acc + term;
        if (energy_acc[sge_pkg::ENERGY_W-1] == term[63]
            && total[sge_pkg::ENERGY_W-1] != energy_acc[sge_pkg::ENERGY_W-1])
        begin
            clipped    = 1'b1;
            energy_acc = energy_acc[sge_pkg::ENERGY_W-1] ? sge_pkg::ENERGY_MIN
                                                         : sge_pkg::ENERGY_MAX;
        end
        else
        begin
            energy_acc = total;
        end
        if (is_last)
        begin
            due.energy    = energy_acc;
            due.saturated = clipped;
            pending_energy.push_back(due);
            clear_vector();
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        energy_result_t want;
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (pending_energy.size() == 0)
            begin
                flag_mismatch("unexpected result beat", result_bus.energy, 0);
            end
            else
            begin
                want = pending_energy.pop_front();
                if (result_bus.energy !== want.energy)
                    flag_mismatch("energy", result_bus.energy, want.energy);
                if (result_bus.saturated !== want.saturated)
                    flag_mismatch("saturated", longint'(result_bus.saturated),
                                  longint'(want.saturated));
            end
        end
    end

    // result side: ready pattern per drain mode, plus long holds on request
    initial
    begin : result_drain
        int holds_served;
        int hold_left;
        int stall_left;
        int phase;
        holds_served = 0;
        hold_left    = 0;
        stall_left   = 0;
        phase        = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            phase = (phase + 1) % 7;
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                case (drain_mode)
                    DRAIN_FREE:    result_bus.ready <= 1'b1;
                    DRAIN_COIN:    result_bus.ready <= 1'($urandom_range(0, 1));
                    DRAIN_PATTERN: result_bus.ready <= (phase >= 3);
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            result_bus.ready <= 1'b0;
                        end
                        else
                        begin
                            stall_left = $urandom_range(0, 8);
                            result_bus.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    function automatic int next_gap();
        if (!sender_bursty)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return $urandom_range(1, 5);
    endfunction

    // called at a clock edge; returns at the edge where the beat is taken
    task automatic send_sample(input logic signed [sge_pkg::SAMPLE_W-1:0] value,
                               input bit is_last);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= value;
        sample_bus.last   <= is_last;
        @(posedge clk);
        while (sample_bus.ready !== 1'b1)
            @(posedge clk);
        absorb_sample(value, is_last);
        items_sent++;
    endtask

    function automatic logic signed [sge_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sge_pkg::SAMPLE_W'($urandom_range(0, 15)) - sge_pkg::SAMPLE_W'(8);
            default: return sge_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_vector(input int length);
        for (int i = 0; i < length; i++)
            send_sample(pick_sample(), i == length - 1);
    endtask

    // stop offering and let every pending beat and the pipeline drain
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (pending_energy.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sge_pkg::CFG_IDX_W-1:0] index,
                             input logic [sge_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (index == sge_pkg::CFG_DIMENSIONS)
        begin
            grid_dims = value[sge_pkg::DIMS_W-1:0];
            clear_vector();
        end
        else if (index == sge_pkg::CFG_SIDE_LENGTH)
        begin
            grid_side = value[sge_pkg::SIDE_LEN_W-1:0];
            clear_vector();
        end
        @(posedge clk);
    endtask

    // dimension code in the low bits, junk above
    task automatic write_dims(input logic [sge_pkg::DIMS_W-1:0] dims);
        write_reg(sge_pkg::CFG_DIMENSIONS,
                  {(sge_pkg::CFG_DATA_W-sge_pkg::DIMS_W)'($urandom()), dims});
    endtask

    function automatic int pick_length();
        int unsigned side;
        int          points;
        int          roll;
        if (grid_dims <= sge_pkg::DIMS_ONE)
            return $urandom_range(1, 80);
        side   = active_side();
        points = (grid_dims == sge_pkg::DIMS_TWO) ? side * side : side * side * side;
        roll   = $urandom_range(0, 9);
        if (points > 200)
            return $urandom_range(1, 150);
        if (roll < 6)
            return points;
        if (roll < 8)
            return $urandom_range(1, points);
        // runs past a full grid, counters wrap to the origin
        return points + $urandom_range(1, (points < 40) ? points : 40);
    endfunction

    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_line_1d();
        settle();
        write_dims(sge_pkg::DIMS_ONE);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_plane_2d();
        settle();
        write_dims(sge_pkg::DIMS_TWO);
        write_reg(sge_pkg::CFG_SIDE_LENGTH, 7'd2);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        // side of one: every sample is its own grid, no neighbors
        settle();
        write_reg(sge_pkg::CFG_SIDE_LENGTH, 7'd1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_cube_3d();
        settle();
        write_dims(sge_pkg::DIMS_THREE);
        write_reg(sge_pkg::CFG_SIDE_LENGTH, 7'd2);
        for (int i = 0; i < 9; i++)
            send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i == 8);
    endtask

    task automatic test_restart_on_write();
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        settle();
        write_reg(CFG_UNMAPPED_FIRST, sge_pkg::CFG_DATA_W'($urandom()));
        write_reg(CFG_UNMAPPED_LAST, sge_pkg::CFG_DATA_W'($urandom()));
        send_sample(pick_sample(), 1'b1);
        send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b0);
        settle();
        write_reg(sge_pkg::CFG_SIDE_LENGTH, 7'd2);
        send_sample(pick_sample(), 1'b1);
    endtask

    task automatic test_backpressure();
        settle();
        write_dims(sge_pkg::DIMS_ONE);
        drain_mode    = DRAIN_FREE;
        sender_bursty = 1'b0;
        hold_requests++;
        for (int v = 0; v < 40; v++)
            send_vector($urandom_range(1, 3));
        settle();
        drain_mode    = DRAIN_COIN;
        sender_bursty = 1'b1;
    endtask

    // one full plane plus a row and one sample, so the first plane entries are read back
    task automatic test_full_plane();
        settle();
        write_dims(sge_pkg::DIMS_THREE);
        write_reg(sge_pkg::CFG_SIDE_LENGTH, sge_pkg::SIDE_LEN_W'(PLANE_SIDE));
        send_vector(PLANE_SIDE * PLANE_SIDE + PLANE_SIDE + 1);
    endtask

    task automatic test_random_vectors();
        int                             target;
        int                             vectors;
        logic [sge_pkg::CFG_DATA_W-1:0] side;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            settle();
            case ($urandom_range(0, 11))
                0:       side = 7'd0;
                1:       side = 7'd1;
                2:       side = 7'd2;
                3:       side = 7'd3;
                4:       side = 7'd127;
                5:       side = 7'd64;
                6:       side = 7'd65;
                default: side = sge_pkg::CFG_DATA_W'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 1))
            begin
                write_dims(sge_pkg::DIMS_W'($urandom_range(sge_pkg::DIMS_NONE,
                                                           sge_pkg::DIMS_THREE)));
                write_reg(sge_pkg::CFG_SIDE_LENGTH, side);
            end
            else
            begin
                write_reg(sge_pkg::CFG_SIDE_LENGTH, side);
                write_dims(sge_pkg::DIMS_W'($urandom_range(sge_pkg::DIMS_NONE,
                                                           sge_pkg::DIMS_THREE)));
            end
            drain_mode    = drain_mode_t'($urandom_range(0, 3));
            sender_bursty = ($urandom_range(0, 3) != 0);
            vectors       = $urandom_range(2, 6);
            for (int v = 0; v < vectors; v++)
                send_vector(pick_length());
        end
    endtask

    initial
    begin
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        sample_bus.last   <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        hold_requests  = 0;
        burst_left     = 0;
        sender_bursty  = 1'b1;
        drain_mode     = DRAIN_COIN;
        grid_dims      = sge_pkg::DIMS_TWO;
        grid_side      = sge_pkg::SIDE_RESET;
        clear_vector();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_line_1d();
        test_plane_2d();
        test_cube_3d();
        test_restart_on_write();
        test_backpressure();
        test_full_plane();
        test_random_vectors();
        settle();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
